// File: src/obcd_pkg.sv
// Shared constants and types of the occupancy bit change detector.
package obcd_pkg;

  localparam int MODULES     = 256;
  localparam int MOD_AW      = $clog2(MODULES);
  localparam int OBJ_W       = 10;
  localparam int WORD_W      = 16;
  localparam int BYTE_W      = 8;
  localparam int PIN_W       = 3;
  localparam int MOD_NUM_W   = 12;
  localparam int CADDR_W     = 12;
  localparam int ADDR_SUM_W  = MOD_AW + PIN_W + 1;
  localparam int CHG_W       = 2 * BYTE_W;
  localparam int CHG_IDX_W   = $clog2(CHG_W);
  localparam int S_TDATA_W   = 32;
  localparam int M_TDATA_W   = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [OBJ_W-1:0] OBJECT_BASE = OBJ_W'(100);

  // One classified report: the two modules it touches and their new contact bytes.
  typedef struct packed {
    logic [MOD_AW-1:0] mod0;
    logic              en0;
    logic [BYTE_W-1:0] byte0;
    logic [MOD_AW-1:0] mod1;
    logic              en1;
    logic [BYTE_W-1:0] byte1;
  } report_t;

endpackage

// File: src/obcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module obcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: src/obcd_front.sv
// Front end: accepts feedback reports and maps them onto module pairs.
module obcd_front
  import obcd_pkg::*;
(
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  output logic                 push_valid,
  input  logic                 push_ready,
  output report_t              push_data
);

  logic [OBJ_W-1:0]     object_number;
  logic [WORD_W-1:0]    state_word;
  logic [OBJ_W-1:0]     pair;
  logic [MOD_NUM_W-1:0] first_mod;
  logic [MOD_NUM_W-1:0] second_mod;
  logic                 en0;
  logic                 en1;
  logic                 keep;

  assign object_number = s_axis_tdata[OBJ_W-1:0];
  assign state_word    = s_axis_tdata[OBJ_W+WORD_W-1:OBJ_W];

  assign pair       = object_number - OBJECT_BASE;
  assign first_mod  = MOD_NUM_W'({pair, 1'b0});
  assign second_mod = MOD_NUM_W'({pair, 1'b1});
  assign en0        = first_mod < MOD_NUM_W'(MODULES);
  assign en1        = second_mod < MOD_NUM_W'(MODULES);

  // Reports below the base number, or whose pair lies past the store, are dropped here.
  assign keep = (object_number >= OBJECT_BASE) && en0;

  assign s_axis_tready = push_ready;
  assign push_valid    = s_axis_tvalid && keep;

  always_comb begin
    push_data.mod0  = first_mod[MOD_AW-1:0];
    push_data.en0   = en0;
    push_data.byte0 = state_word[BYTE_W-1:0];
    push_data.mod1  = second_mod[MOD_AW-1:0];
    push_data.en1   = en1;
    push_data.byte1 = state_word[WORD_W-1:BYTE_W];
  end

endmodule

// File: src/obcd_queue.sv
// Short FIFO of classified reports between the front end and the back end.
module obcd_queue
  import obcd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push_valid,
  output logic    push_ready,
  input  report_t push_data,
  output logic    pop_valid,
  input  logic    pop_ready,
  output report_t pop_data
);

  report_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;
  logic                do_push;
  logic                do_pop;

  assign push_ready = count != (QPTR_W+1)'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers wrap naturally since the depth is a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

// File: src/obcd_back.sv
// Back end: compares reports with the module store and emits one result per changed contact.
module obcd_back
  import obcd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  report_t              pop_data,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  output logic                 m_axis_tlast
);

  typedef enum logic [1:0] {
    S_RD0,
    S_RD1,
    S_CMP1,
    S_EMIT
  } state_t;

  state_t                state;
  report_t               cur;
  logic [CHG_W-1:0]      mask;
  logic [MODULES-1:0]    vld;
  logic                  rd_vld;

  logic [MOD_AW-1:0]     rd_addr;
  logic [BYTE_W-1:0]     rd_data;
  logic                  wr_en;
  logic [MOD_AW-1:0]     wr_addr;
  logic [BYTE_W-1:0]     wr_data;
  logic [BYTE_W-1:0]     old_byte;
  logic [BYTE_W-1:0]     diff0;
  logic [BYTE_W-1:0]     diff1;

  logic [CHG_W-1:0]      low_bit;
  logic [CHG_W-1:0]      rest;
  logic [CHG_IDX_W-1:0]  idx;
  logic [MOD_AW-1:0]     sel_mod;
  logic [BYTE_W-1:0]     sel_byte;
  logic [PIN_W-1:0]      pin;
  logic [ADDR_SUM_W-1:0] addr_sum;
  logic                  out_free;

  obcd_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(MODULES)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign pop_ready = state == S_RD0;
  assign rd_addr   = (state == S_RD0) ? pop_data.mod0 : cur.mod1;

  // A module never written since reset reads as all contacts free.
  assign old_byte = rd_vld ? rd_data : '0;
  assign diff0    = cur.en0 ? (old_byte ^ cur.byte0) : '0;
  assign diff1    = cur.en1 ? (old_byte ^ cur.byte1) : '0;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur.mod0;
    wr_data = cur.byte0;
    case (state)
      S_RD1: begin
        wr_en = cur.en0;
      end
      S_CMP1: begin
        wr_en   = cur.en1;
        wr_addr = cur.mod1;
        wr_data = cur.byte1;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Lowest pending change first: module 0 occupies mask bits 7..0, module 1 bits 15..8.
  always_comb begin
    low_bit = mask & (~mask + CHG_W'(1));
    rest    = mask & ~low_bit;
    idx     = '0;
    for (int i = 0; i < CHG_W; i++) begin
      if (low_bit[i]) begin
        idx = idx | CHG_IDX_W'(i);
      end
    end
    pin      = idx[PIN_W-1:0];
    sel_mod  = idx[CHG_IDX_W-1] ? cur.mod1 : cur.mod0;
    sel_byte = idx[CHG_IDX_W-1] ? cur.byte1 : cur.byte0;
    addr_sum = ADDR_SUM_W'({sel_mod, pin}) + ADDR_SUM_W'(1);
  end

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= vld[rd_addr];
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_RD0;
      mask          <= '0;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
      m_axis_tlast  <= 1'b0;
    end else begin
      if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_RD0: begin
          if (pop_valid) begin
            cur   <= pop_data;
            state <= S_RD1;
          end
        end
        S_RD1: begin
          mask[BYTE_W-1:0] <= diff0;
          state            <= S_CMP1;
        end
        S_CMP1: begin
          mask[CHG_W-1:BYTE_W] <= diff1;
          state                <= S_EMIT;
        end
        S_EMIT: begin
          if (mask == '0) begin
            state <= S_RD0;
          end else if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= M_TDATA_W'({sel_byte[pin], CADDR_W'(addr_sum)});
            m_axis_tlast  <= rest == '0;
            mask          <= rest;
            if (rest == '0) begin
              state <= S_RD0;
            end
          end
        end
        default: begin
          state <= S_RD0;
        end
      endcase
    end
  end

endmodule

// File: src/occupancy_bit_change_detector.sv
// Top level of the occupancy bit change detector.
// A report is taken every cycle while the two-entry queue has room.
// The back end reads and compares both modules in states S_RD0, S_RD1 and S_CMP1, then
// emits one result per changed contact (0 to 16) in S_EMIT, pausing on a stalled output.
// It takes the next report only after the last result of the current one is registered.
// Synchronous reset empties the queue, drops pending results and marks every module free.
module occupancy_bit_change_detector
  import obcd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [9:0] object_number, [25:10] state_word
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // [11:0] contact_address, [12] occupied
  output logic                 m_axis_tlast
);

  logic    push_valid;
  logic    push_ready;
  report_t push_data;
  logic    pop_valid;
  logic    pop_ready;
  report_t pop_data;

  obcd_front u_front (
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_data    (push_data)
  );

  obcd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  obcd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_data     (pop_data),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

// File: src/obcd_checker.sv
// Port-level checks of the occupancy bit change detector and their binding.
module obcd_checker
  import obcd_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [S_TDATA_W-1:0] s_axis_tdata,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic                 m_axis_tlast
);

  // Reset leaves no stale result on the output.
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // A waiting request keeps its contents until it is taken.
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
    else $error("waiting request changed");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // Contact addresses start at one and the spare bits stay zero.
  a_addr_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[CADDR_W-1:0] != '0 &&
      m_axis_tdata[M_TDATA_W-1:CADDR_W+1] == '0)
    else $error("bad contact address or padding");

  // Within one report the contacts come in ascending address order.
  a_ascending: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      !m_axis_tvalid ||
      m_axis_tdata[CADDR_W-1:0] > $past(m_axis_tdata[CADDR_W-1:0]))
    else $error("contacts out of order within a report");

endmodule

bind occupancy_bit_change_detector obcd_checker u_obcd_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);
